@@ hdl/prr_pkg.sv @@
// Shared types and constants for the palette range rotator.
`timescale 1ns / 1ps
package prr_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int MAP_DEPTH   = 256;
    localparam int NUM_REGS    = 8;
    localparam int CFG_IW      = 3;
    localparam int CFG_DW      = 49;

    localparam int SCAN_W = $clog2(NUM_ENTRIES + 1);
    localparam int ENT_IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int MAP_AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam logic [8:0] MAP_LIMIT = 9'(MAP_DEPTH);

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] palette_index;
    } req_t;

    typedef struct packed {
        logic       changed;
        logic [7:0] color_index;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  high;
        logic [7:0]  low;
        logic [15:0] period;
        logic [15:0] init;
        logic        enable;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic rd_lookup;
        logic emit_lookup;
        logic emit_tick;
        logic step_timer;
        logic rd_hi;
        logic load_carry;
        logic shift;
        logic next_entry;
    } prr_cmd_t;

    typedef struct packed {
        logic stop;
        logic active;
        logic hit;
        logic at_hi;
    } prr_stat_t;

endpackage

@@ hdl/prr_ctrl.sv @@
// Control state machine: sequences lookups, the entry scan and range rotations.
`timescale 1ns / 1ps
module prr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              opcode,
    input  prr_pkg::prr_stat_t stat,
    output prr_pkg::prr_cmd_t  cmd,
    output logic              busy
);
    import prr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_LEMIT = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CARRY = 3'd4;
    localparam logic [2:0] S_RUN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = (opcode == OP_LOOKUP) ? S_LOOK : S_SCAN;
                end
            end
            S_LOOK:
            begin
                cmd.rd_lookup = 1'b1;
                state_next    = S_LEMIT;
            end
            S_LEMIT:
            begin
                cmd.emit_lookup = 1'b1;
                state_next      = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.stop)
                begin
                    cmd.emit_tick = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (!stat.active)
                begin
                    cmd.next_entry = 1'b1;
                end
                else if (!stat.hit)
                begin
                    cmd.step_timer = 1'b1;
                    cmd.next_entry = 1'b1;
                end
                else
                begin
                    // reload the timer and fetch the top entry of the range
                    cmd.step_timer = 1'b1;
                    cmd.rd_hi      = 1'b1;
                    state_next     = S_CARRY;
                end
            end
            S_CARRY:
            begin
                cmd.load_carry = 1'b1;
                state_next     = S_RUN;
            end
            S_RUN:
            begin
                cmd.shift = 1'b1;
                if (stat.at_hi)
                begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ hdl/prr_datapath.sv @@
// Datapath: entry registers, timers, remap memory, rotation carry and result register.
`timescale 1ns / 1ps
module prr_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  prr_pkg::req_t              req,
    input  logic                       cfg_we,
    input  logic [prr_pkg::CFG_IW-1:0] cfg_index,
    input  logic [prr_pkg::CFG_DW-1:0] cfg_data,
    input  prr_pkg::prr_cmd_t          cmd,
    output prr_pkg::prr_stat_t         stat,
    output logic                       done,
    output prr_pkg::rsp_t              rsp
);
    import prr_pkg::*;

    entry_t      entry_reg [NUM_ENTRIES];
    logic [15:0] timer_reg [NUM_ENTRIES];
    logic [SCAN_W-1:0] scan_reg;
    logic [7:0]  idx_reg;
    logic        changed_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  carry_reg;
    logic [7:0]  rd_data_reg;
    logic        map_valid_reg [MAP_DEPTH];
    logic [7:0]  map_mem [MAP_DEPTH];
    logic        done_reg;
    rsp_t        rsp_reg;

    entry_t      cur;
    logic [15:0] cur_timer;
    logic        in_range;
    logic        cfg_hit;
    logic        rd_en;
    logic [7:0]  rd_addr;
    logic [ENT_IW-1:0] ent_sel;

    assign ent_sel   = scan_reg[ENT_IW-1:0];
    assign cur       = entry_reg[ent_sel];
    assign cur_timer = timer_reg[ent_sel];
    assign in_range  = (scan_reg < SCAN_W'(NUM_ENTRIES));
    assign cfg_hit   = cfg_we && ({1'b0, cfg_index} < (CFG_IW + 1)'(NUM_ENTRIES));

    assign stat.stop   = !in_range || (cur.period == 16'd0);
    assign stat.active = cur.enable && (cur.low < cur.high) && ({1'b0, cur.high} < MAP_LIMIT);
    assign stat.hit    = (cur_timer == 16'd1);
    assign stat.at_hi  = (addr_reg == cur.high);

    always_comb
    begin
        rd_en   = cmd.rd_lookup | cmd.rd_hi | cmd.load_carry | cmd.shift;
        rd_addr = addr_reg + 8'd1;
        if (cmd.rd_lookup)
        begin
            rd_addr = idx_reg;
        end
        else if (cmd.rd_hi)
        begin
            rd_addr = cur.high;
        end
        else if (cmd.load_carry)
        begin
            rd_addr = addr_reg;
        end
    end

    // entries and timers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                entry_reg[i] <= '0;
                timer_reg[i] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            entry_reg[cfg_index[ENT_IW-1:0]] <= entry_t'(cfg_data);
            timer_reg[cfg_index[ENT_IW-1:0]] <= cfg_data[16:1];
        end
        else if (cmd.step_timer)
        begin
            timer_reg[ent_sel] <= stat.hit ? cur.period : cur_timer - 16'd1;
        end
    end

    // sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= '0;
            changed_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_lookup | cmd.emit_tick;
            if (cmd.accept)
            begin
                scan_reg    <= '0;
                changed_reg <= 1'b0;
            end
            else
            begin
                if (cmd.next_entry)
                begin
                    scan_reg <= scan_reg + SCAN_W'(1);
                end
                if (cmd.step_timer && stat.hit)
                begin
                    changed_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= req.palette_index;
        end
        if (cmd.rd_hi)
        begin
            addr_reg <= cur.low;
        end
        else if (cmd.shift)
        begin
            addr_reg <= addr_reg + 8'd1;
        end
        if (cmd.load_carry || cmd.shift)
        begin
            carry_reg <= rd_data_reg;
        end
        if (cmd.emit_lookup)
        begin
            rsp_reg.changed     <= 1'b0;
            rsp_reg.color_index <= ({1'b0, idx_reg} < MAP_LIMIT) ? rd_data_reg : 8'd0;
        end
        else if (cmd.emit_tick)
        begin
            rsp_reg.changed     <= changed_reg;
            rsp_reg.color_index <= 8'd0;
        end
    end

    // an entry never written reads as its own index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_DEPTH; i++)
            begin
                map_valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.shift)
        begin
            map_valid_reg[addr_reg[MAP_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            map_mem[addr_reg[MAP_AW-1:0]] <= carry_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_valid_reg[rd_addr[MAP_AW-1:0]] ?
                           map_mem[rd_addr[MAP_AW-1:0]] : rd_addr;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ hdl/palette_range_rotator.sv @@
// Top level of the palette range rotator: controller plus datapath.
`timescale 1ns / 1ps
// Palette color-cycling remap block.
// Request channel: a request is taken at a clock edge with start high and busy
// low. opcode 1 looks up palette_index in the 256-entry remap table; opcode 0
// advances one tick over the eight cycling entries.
// Result channel: done pulses for one cycle with rsp; the receiver cannot stall
// it. Every request gives exactly one result.
// A lookup reads the table entry and then registers it as the result. A tick
// scans the entries in order, stops at the first zero period or after the last
// entry, and rotates each range whose timer expires before moving on.
// The remap memory moves one table entry per cycle and bounds the
// rotation time.
// A new request is taken in the cycle its predecessor's result is shown.
// Configuration: cfg_we writes entry register cfg_index and reloads its timer;
// write only while busy is low.
// Reset: the table reads as identity (per-entry valid bits clear at once), all
// entry registers and timers clear, and the block is ready right away.
module palette_range_rotator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  prr_pkg::req_t              req,
    output logic                       done,
    output prr_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [prr_pkg::CFG_IW-1:0] cfg_index,
    input  logic [prr_pkg::CFG_DW-1:0] cfg_data
);
    import prr_pkg::*;

    prr_cmd_t  cmd;
    prr_stat_t stat;

    prr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    prr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

@@ hdl/prr_checker.sv @@
// Port-level checks for the palette range rotator, bound to the top level.
`timescale 1ns / 1ps
module prr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input prr_pkg::rsp_t rsp
);
    import prr_pkg::*;

    // an accepted request always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a request");

    // a result only follows a cycle of work
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // the block is idle while a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // a result that flags a change, which only a tick gives, carries no color
    a_rsp_shape: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.changed |-> rsp.color_index == 8'd0)
        else $error("result mixes tick and lookup fields");

endmodule

bind palette_range_rotator prr_checker u_prr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

@@ test/palette_range_rotator_tb.sv @@
// Palette range rotator testbench: directed and random ticks and lookups, checked by a scoreboard.
`timescale 1ns / 1ps
module palette_range_rotator_tb;

    import prr_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE_TICKS = 20;

    // Mirror of the remap table and cycling entries; predicts one result per request.
    class remap_scoreboard;
        logic [7:0]  color_map [MAP_DEPTH];
        logic [15:0] timer [NUM_ENTRIES];
        entry_t      entries [NUM_ENTRIES];
        rsp_t        expected_rsp [$];
        int          errors;

        function new();
            int k;
            for (k = 0; k < MAP_DEPTH; k++)
                color_map[k] = 8'(k);
            for (k = 0; k < NUM_ENTRIES; k++)
            begin
                entries[k] = '0;
                timer[k] = '0;
            end
            errors = 0;
        endfunction

        function void write_entry(int idx, entry_t e);
            if (idx < NUM_ENTRIES)
            begin
                entries[idx] = e;
                timer[idx] = e.init;
            end
        endfunction

        function rsp_t predict_remap(req_t r);
            rsp_t       res;
            logic [7:0] top;
            int         i;
            int         j;
            int         lo;
            int         hi;
            res = '0;
            if (r.opcode == OP_LOOKUP)
            begin
                if (int'(r.palette_index) < MAP_DEPTH)
                    res.color_index = color_map[r.palette_index];
            end
            else
            begin
                for (i = 0; i < NUM_ENTRIES; i++)
                begin
                    lo = int'(entries[i].low);
                    hi = int'(entries[i].high);
                    // a zero period ends the scan
                    if (entries[i].period == 16'd0)
                        break;
                    if (!entries[i].enable || lo >= hi || hi >= MAP_DEPTH)
                        continue;
                    timer[i] = timer[i] - 16'd1;
                    if (timer[i] == 16'd0)
                    begin
                        res.changed = 1'b1;
                        timer[i] = entries[i].period;
                        // rotate up: old top entry lands at the low end
                        top = color_map[hi];
                        for (j = hi; j > lo; j--)
                            color_map[j] = color_map[j - 1];
                        color_map[lo] = top;
                    end
                end
            end
            return res;
        endfunction

        function void note_request(req_t r);
            expected_rsp.push_back(predict_remap(r));
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp_rsp;
            if (expected_rsp.size() == 0)
            begin
                $error("result with no request outstanding: changed=%0d color_index=%0d",
                       got.changed, got.color_index);
                errors++;
                return;
            end
            exp_rsp = expected_rsp.pop_front();
            if (got.changed !== exp_rsp.changed)
            begin
                $error("changed mismatch: expected %0d, actual %0d", exp_rsp.changed, got.changed);
                errors++;
            end
            if (got.color_index !== exp_rsp.color_index)
            begin
                $error("color_index mismatch: expected %0d, actual %0d",
                       exp_rsp.color_index, got.color_index);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    req_t                req = '0;
    logic                done;
    rsp_t                rsp;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;

    remap_scoreboard     sb;
    int unsigned         cycle_count = 0;

    palette_range_rotator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** palette_range_rotator: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    // Hold the request until the block takes it; leaves start high.
    task automatic send_request(req_t r);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
    endtask

    task automatic send_op(logic op, logic [7:0] idx);
        req_t r;
        r.opcode = op;
        r.palette_index = idx;
        send_request(r);
    endtask

    // Wait until every expected result is in and the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_rsp.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic load_entries(entry_t set [NUM_ENTRIES]);
        int k;
        for (k = 0; k < NUM_ENTRIES; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IW'(k);
            cfg_data <= set[k];
            @(posedge clk);
            sb.write_entry(k, set[k]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic entry_t random_entry();
        entry_t e;
        int     pick;
        e.enable = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 15);
        if (pick == 0)
            e.period = 16'd0;
        else if (pick == 1)
            e.period = 16'($urandom);
        else
            e.period = 16'($urandom_range(1, 6));
        pick = $urandom_range(0, 7);
        if (pick == 0)
            e.init = 16'($urandom);
        else if (pick == 1)
            e.init = 16'd0;
        else
            e.init = 16'($urandom_range(1, 6));
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            e.low = 8'd0;
            e.high = 8'd255;
        end
        else if (pick < 3)
        begin
            // empty or inverted range
            e.low = 8'($urandom_range(0, 255));
            e.high = 8'($urandom_range(0, e.low));
        end
        else
        begin
            e.low = 8'($urandom_range(0, 240));
            e.high = e.low + 8'($urandom_range(1, 15));
        end
        return e;
    endfunction

    task automatic run_items(int count, int gap_max);
        int n;
        int burst;
        int gap;
        burst = $urandom_range(1, 10);
        for (n = 0; n < count; n++)
        begin
            send_op(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 10);
                gap = $urandom_range(0, gap_max);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        entry_t set [NUM_ENTRIES];
        int     p;
        int     k;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity table, no entries configured
        send_op(OP_LOOKUP, 8'd0);
        send_op(OP_LOOKUP, 8'd255);
        send_op(OP_TICK, 8'd0);
        send_op(OP_LOOKUP, 8'hAA);
        send_op(OP_LOOKUP, 8'h55);
        drain_results();

        // full-table rotation, normal range, empty and inverted ranges,
        // disabled entry, timer wrap, zero period stopping the scan
        set[0] = '{high: 8'd255, low: 8'd0,  period: 16'd1, init: 16'd1, enable: 1'b1};
        set[1] = '{high: 8'd20,  low: 8'd10, period: 16'd3, init: 16'd2, enable: 1'b1};
        set[2] = '{high: 8'd30,  low: 8'd30, period: 16'd1, init: 16'd1, enable: 1'b1};
        set[3] = '{high: 8'd50,  low: 8'd40, period: 16'd1, init: 16'd1, enable: 1'b0};
        set[4] = '{high: 8'd50,  low: 8'd60, period: 16'd1, init: 16'd1, enable: 1'b1};
        set[5] = '{high: 8'd101, low: 8'd100, period: 16'd2, init: 16'd0, enable: 1'b1};
        set[6] = '0;
        set[7] = '1;
        load_entries(set);
        send_op(OP_TICK, 8'd0);
        send_op(OP_LOOKUP, 8'd0);
        send_op(OP_LOOKUP, 8'd255);
        send_op(OP_LOOKUP, 8'd1);
        send_op(OP_TICK, 8'hFF);
        send_op(OP_TICK, 8'd0);
        send_op(OP_LOOKUP, 8'd10);
        send_op(OP_LOOKUP, 8'd20);
        send_op(OP_LOOKUP, 8'd15);
        send_op(OP_TICK, 8'd0);
        send_op(OP_LOOKUP, 8'd100);
        send_op(OP_LOOKUP, 8'd30);
        send_op(OP_LOOKUP, 8'd45);
        send_op(OP_LOOKUP, 8'd60);

        for (p = 0; p < 6; p++)
        begin
            drain_results();
            for (k = 0; k < NUM_ENTRIES; k++)
                set[k] = random_entry();
            load_entries(set);
            run_items(45, (p == 2) ? 0 : 5);
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("** palette_range_rotator: PASSED **");
        else
            $display("** palette_range_rotator: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
hdl/prr_pkg.sv
hdl/prr_ctrl.sv
hdl/prr_datapath.sv
hdl/palette_range_rotator.sv
hdl/prr_checker.sv
test/palette_range_rotator_tb.sv
